// ===== hw/rtl/fwm_pkg.sv =====
// shared types and constants for the fixed window modular exponentiation engine
`timescale 1ns / 1ps
`default_nettype none
package fwm_pkg;

    localparam int LIMB = 64;

    localparam logic [1:0] MODE_MOD   = 2'd0;
    localparam logic [1:0] MODE_BASE  = 2'd1;
    localparam logic [1:0] MODE_EXP   = 2'd2;
    localparam logic [1:0] MODE_START = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RUN  = 6'b000010,
        S_NEXT = 6'b000100,
        S_SCAN = 6'b001000,
        S_RD   = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef enum logic [4:0] {
        J_ONE  = 5'b00001,
        J_BASE = 5'b00010,
        J_TBL  = 5'b00100,
        J_SQ   = 5'b01000,
        J_WMUL = 5'b10000
    } t_job;

    // control for one step of the cell row
    typedef struct packed {
        logic dbl;
        logic bin;
    } t_row_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/fixed_window_modexp.sv =====
// top level of the fixed window modular exponentiation engine
//
// channel  dir  tdata (low bit up)                 tlast  tuser
// s_axis   in   word_index[5:0], word_value[69:6]  -      mode[1:0]
// m_axis   out  result_word[63:0], index[69:64]    last   error
//
// a load transaction is taken while the engine is idle; a start stalls intake until the last
// result word is taken
// each modular multiply or reduce steps through the cell row, a double and then a
// conditional add per operand bit, and then hands over its result; a zero modulus
// skips the loop and goes straight to the result words
// reset is synchronous active low and clears the modulus and the control state
// output words hold while m_axis_tready is low
`timescale 1ns / 1ps
`default_nettype none
module fixed_window_modexp #(
    parameter int WIDTH = 256,
    parameter int WIN_W = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // word_index, word_value, zero pad
    input  wire logic [1:0]  s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [71:0] m_axis_tdata,   // result_word, result_index, zero pad
    output logic             m_axis_tlast,   // last
    output logic             m_axis_tuser    // error
);
    localparam int WORDS = (WIDTH + 63) / 64;
    localparam int LW    = WORDS * 64;
    localparam int KW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int TS    = 1 << WIN_W;
    localparam int NW    = (WIDTH + WIN_W - 1) / WIN_W;
    localparam int WW    = (NW > 1) ? $clog2(NW) : 1;
    localparam int EP    = NW * WIN_W;
    localparam int CW    = $clog2(WIDTH);
    localparam int SW    = $clog2(WIN_W) + 1;
    localparam logic [LW-1:0] MASK = {LW{1'b1}} >> (LW - WIDTH);

    // operand stores
    logic [LW-1:0]          r_mod;
    logic [LW-1:0]          r_base;
    logic [LW-1:0]          r_exp;

    // working registers of the multiply / reduce loop
    logic [LW-1:0]          r_r;
    logic [LW-1:0]          r_a;
    logic [LW-1:0]          r_b;
    logic [LW-1:0]          r_acc;
    logic [LW-1:0]          r_p1;
    logic                   r_red;
    logic                   r_ph;
    logic [CW-1:0]          r_cnt;

    fwm_pkg::t_state        r_state;
    fwm_pkg::t_job          r_job;
    logic [WIN_W-1:0]       r_t;
    logic [SW-1:0]          r_sq;
    logic [WW-1:0]          r_w;
    logic                   r_started;
    logic [KW-1:0]          r_k;
    logic                   r_err;

    logic [1:0]             in_mode;
    logic [5:0]             in_idx;
    logic [63:0]            in_val;
    logic                   in_fire;
    logic                   in_slot_ok;
    logic [KW-1:0]          in_slot;

    fwm_pkg::t_row_ctl      row_ctl;
    logic [LW-1:0]          row_r;
    logic                   bmsb;
    logic [EP-1:0]          e_pad;
    logic [WIN_W-1:0]       win_sel;

    logic                   tbl_wr;
    logic [WIN_W-1:0]       tbl_wr_addr;
    logic [LW-1:0]          tbl_rd_data;
    logic                   out_fire;

    assign in_mode    = s_axis_tuser;
    assign in_idx     = s_axis_tdata[5:0];
    assign in_val     = s_axis_tdata[69:6];
    assign in_fire    = s_axis_tvalid & s_axis_tready;
    assign in_slot_ok = (7'(in_idx) < 7'(WORDS));
    assign in_slot    = in_idx[KW-1:0];
    assign out_fire   = m_axis_tvalid & m_axis_tready;

    assign s_axis_tready = (r_state == fwm_pkg::S_IDLE);

    // cell row step
    assign bmsb        = r_b[WIDTH-1];
    assign row_ctl.dbl = ~r_ph;
    assign row_ctl.bin = r_red & bmsb;

    fwm_row #(.WORDS(WORDS)) u_row (
        .i_ctl (row_ctl),
        .i_r   (r_r),
        .i_a   (r_a),
        .i_m   (r_mod),
        .o_r   (row_r)
    );

    // exponent window under the scan pointer
    assign e_pad   = EP'(r_exp[WIDTH-1:0]);
    assign win_sel = WIN_W'(e_pad >> (32'(r_w) * WIN_W));

    // table written as each entry finishes
    always_comb begin
        tbl_wr      = 1'b0;
        tbl_wr_addr = r_t;
        if (r_state == fwm_pkg::S_NEXT) begin
            case (r_job)
                fwm_pkg::J_ONE: begin
                    tbl_wr      = 1'b1;
                    tbl_wr_addr = '0;
                end
                fwm_pkg::J_BASE: begin
                    tbl_wr      = 1'b1;
                    tbl_wr_addr = WIN_W'(1);
                end
                fwm_pkg::J_TBL: begin
                    tbl_wr      = 1'b1;
                    tbl_wr_addr = r_t;
                end
                default: begin
                    tbl_wr      = 1'b0;
                end
            endcase
        end
    end

    fwm_table #(.LW(LW), .WB(WIN_W)) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (r_r),
        .i_rd_addr (win_sel),
        .o_rd_data (tbl_rd_data)
    );

    // operand loads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= '0;
        end else if (in_fire && in_slot_ok && in_mode == fwm_pkg::MODE_MOD) begin
            r_mod[in_slot*64 +: 64] <= in_val & MASK[in_slot*64 +: 64];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && in_slot_ok && in_mode == fwm_pkg::MODE_BASE) begin
            r_base[in_slot*64 +: 64] <= in_val & MASK[in_slot*64 +: 64];
        end
        if (in_fire && in_slot_ok && in_mode == fwm_pkg::MODE_EXP) begin
            r_exp[in_slot*64 +: 64] <= in_val & MASK[in_slot*64 +: 64];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fwm_pkg::S_IDLE;
            r_job     <= fwm_pkg::J_ONE;
            r_ph      <= 1'b0;
            r_cnt     <= '0;
            r_t       <= '0;
            r_sq      <= '0;
            r_w       <= '0;
            r_started <= 1'b0;
            r_k       <= '0;
            r_err     <= 1'b0;
            r_red     <= 1'b0;
        end else begin
            case (r_state)
                fwm_pkg::S_IDLE: begin
                    if (in_fire && in_mode == fwm_pkg::MODE_START) begin
                        r_k <= '0;
                        if (~|r_mod) begin
                            r_err   <= 1'b1;
                            r_state <= fwm_pkg::S_OUT;
                        end else begin
                            // reduce the constant one
                            r_err   <= 1'b0;
                            r_r     <= '0;
                            r_b     <= LW'(1);
                            r_red   <= 1'b1;
                            r_ph    <= 1'b0;
                            r_cnt   <= '0;
                            r_job   <= fwm_pkg::J_ONE;
                            r_state <= fwm_pkg::S_RUN;
                        end
                    end
                end
                fwm_pkg::S_RUN: begin
                    if (!r_ph) begin
                        r_r  <= row_r;
                        r_ph <= 1'b1;
                    end else begin
                        if (!r_red && bmsb) begin
                            r_r <= row_r;
                        end
                        r_ph <= 1'b0;
                        r_b  <= r_b << 1;
                        if (r_cnt == CW'(WIDTH - 1)) begin
                            r_cnt   <= '0;
                            r_state <= fwm_pkg::S_NEXT;
                        end else begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end
                end
                fwm_pkg::S_NEXT: begin
                    case (r_job)
                        fwm_pkg::J_ONE: begin
                            r_acc   <= r_r;
                            r_r     <= '0;
                            r_b     <= r_base;
                            r_red   <= 1'b1;
                            r_job   <= fwm_pkg::J_BASE;
                            r_state <= fwm_pkg::S_RUN;
                        end
                        fwm_pkg::J_BASE: begin
                            r_p1 <= r_r;
                            if (TS > 2) begin
                                r_a     <= r_r;
                                r_b     <= r_r;
                                r_r     <= '0;
                                r_red   <= 1'b0;
                                r_t     <= WIN_W'(2);
                                r_job   <= fwm_pkg::J_TBL;
                                r_state <= fwm_pkg::S_RUN;
                            end else begin
                                r_w       <= WW'(NW - 1);
                                r_started <= 1'b0;
                                r_state   <= fwm_pkg::S_SCAN;
                            end
                        end
                        fwm_pkg::J_TBL: begin
                            if (r_t == WIN_W'(TS - 1)) begin
                                r_w       <= WW'(NW - 1);
                                r_started <= 1'b0;
                                r_state   <= fwm_pkg::S_SCAN;
                            end else begin
                                r_t     <= r_t + WIN_W'(1);
                                r_a     <= r_r;
                                r_b     <= r_p1;
                                r_r     <= '0;
                                r_state <= fwm_pkg::S_RUN;
                            end
                        end
                        fwm_pkg::J_SQ: begin
                            r_acc <= r_r;
                            if (r_sq == SW'(WIN_W - 1)) begin
                                // table entry is read under win_sel meanwhile
                                r_state <= fwm_pkg::S_RD;
                            end else begin
                                r_sq    <= r_sq + SW'(1);
                                r_a     <= r_r;
                                r_b     <= r_r;
                                r_r     <= '0;
                                r_state <= fwm_pkg::S_RUN;
                            end
                        end
                        fwm_pkg::J_WMUL: begin
                            r_acc <= r_r;
                            if (r_w == '0) begin
                                r_state <= fwm_pkg::S_OUT;
                            end else begin
                                r_w     <= r_w - WW'(1);
                                r_state <= fwm_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            r_state <= fwm_pkg::S_IDLE;
                        end
                    endcase
                end
                fwm_pkg::S_SCAN: begin
                    if (!r_started && win_sel == '0) begin
                        // leading zero windows are skipped
                        if (r_w == '0) begin
                            r_state <= fwm_pkg::S_OUT;
                        end else begin
                            r_w <= r_w - WW'(1);
                        end
                    end else begin
                        r_started <= 1'b1;
                        r_a       <= r_acc;
                        r_b       <= r_acc;
                        r_r       <= '0;
                        r_red     <= 1'b0;
                        r_sq      <= '0;
                        r_job     <= fwm_pkg::J_SQ;
                        r_state   <= fwm_pkg::S_RUN;
                    end
                end
                fwm_pkg::S_RD: begin
                    r_a     <= tbl_rd_data;
                    r_b     <= r_acc;
                    r_r     <= '0;
                    r_job   <= fwm_pkg::J_WMUL;
                    r_state <= fwm_pkg::S_RUN;
                end
                fwm_pkg::S_OUT: begin
                    if (out_fire) begin
                        if (r_k == KW'(WORDS - 1)) begin
                            r_k     <= '0;
                            r_state <= fwm_pkg::S_IDLE;
                        end else begin
                            r_k <= r_k + KW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= fwm_pkg::S_IDLE;
                end
            endcase
        end
    end

    // result words straight from the accumulator, or zero on an error
    assign m_axis_tvalid = (r_state == fwm_pkg::S_OUT);
    assign m_axis_tdata  = {2'b00, 6'(r_k), r_err ? 64'd0 : r_acc[r_k*64 +: 64]};
    assign m_axis_tlast  = (r_k == KW'(WORDS - 1));
    assign m_axis_tuser  = r_err;

    // intake and result delivery never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("intake open while results pending");

    // error words carry zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("error word not zero");

    // last flag only on the top word
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[69:64] == 6'(WORDS - 1)))
        else $error("last flag on wrong word");

    // a start with a nonzero modulus leads into the loop
    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && in_mode == fwm_pkg::MODE_START && |r_mod)
        |=> (r_state == fwm_pkg::S_RUN))
        else $error("start did not launch the loop");

endmodule
`default_nettype wire

// ===== hw/rtl/fwm_cell.sv =====
// one 64-bit limb of the modular double / add and subtract chain
`timescale 1ns / 1ps
`default_nettype none
module fwm_cell (
    input  wire logic        i_dbl,
    input  wire logic [63:0] i_r,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_m,
    input  wire logic        i_cin,
    input  wire logic        i_bin,
    output logic      [63:0] o_sum,
    output logic             o_cout,
    output logic      [63:0] o_diff,
    output logic             o_bout
);
    logic [64:0] wide;
    logic [64:0] dwide;

    always_comb begin
        if (i_dbl) begin
            wide = {i_r, i_cin};
        end else begin
            wide = {1'b0, i_r} + {1'b0, i_a} + {64'd0, i_cin};
        end
        dwide = {1'b0, wide[63:0]} - {1'b0, i_m} - {64'd0, i_bin};
    end

    assign o_sum  = wide[63:0];
    assign o_cout = wide[64];
    assign o_diff = dwide[63:0];
    assign o_bout = dwide[64];
endmodule
`default_nettype wire

// ===== hw/rtl/fwm_row.sv =====
// row of limb cells: r <- (2r + b) mod m or (r + a) mod m
`timescale 1ns / 1ps
`default_nettype none
module fwm_row #(
    parameter int WORDS = 4
) (
    input  wire fwm_pkg::t_row_ctl     i_ctl,
    input  wire logic [WORDS*64-1:0]   i_r,
    input  wire logic [WORDS*64-1:0]   i_a,
    input  wire logic [WORDS*64-1:0]   i_m,
    output logic      [WORDS*64-1:0]   o_r
);
    logic [WORDS:0]          carry;
    logic [WORDS:0]          borrow;
    logic [WORDS*64-1:0]     sum;
    logic [WORDS*64-1:0]     diff;
    logic                    ge;

    assign carry[0]  = i_ctl.dbl & i_ctl.bin;
    assign borrow[0] = 1'b0;

    for (genvar g = 0; g < WORDS; g++) begin : g_cell
        fwm_cell u_cell (
            .i_dbl  (i_ctl.dbl),
            .i_r    (i_r[g*64 +: 64]),
            .i_a    (i_a[g*64 +: 64]),
            .i_m    (i_m[g*64 +: 64]),
            .i_cin  (carry[g]),
            .i_bin  (borrow[g]),
            .o_sum  (sum[g*64 +: 64]),
            .o_cout (carry[g+1]),
            .o_diff (diff[g*64 +: 64]),
            .o_bout (borrow[g+1])
        );
    end

    // carry out of the top means the value is above any modulus
    assign ge  = carry[WORDS] | ~borrow[WORDS];
    assign o_r = ge ? diff : sum;
endmodule
`default_nettype wire

// ===== hw/rtl/fwm_table.sv =====
// power table memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module fwm_table #(
    parameter int LW = 256,
    parameter int WB = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [WB-1:0] i_wr_addr,
    input  wire logic [LW-1:0] i_wr_data,
    input  wire logic [WB-1:0] i_rd_addr,
    output logic      [LW-1:0] o_rd_data
);
    logic [LW-1:0] mem [1<<WB];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ===== dv/fixed_window_modexp_tb.sv =====
// self-checking testbench for the fixed window modular exponentiation engine
`timescale 1ns / 1ps
module fixed_window_modexp_tb;

    localparam int OPW   = 256;
    localparam int NWORD = OPW / 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // word_index[5:0], word_value[69:6], zero pad
    logic [1:0]  s_axis_tuser;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // result_word[63:0], result_index[69:64], zero pad
    logic        m_axis_tlast;   // last
    logic        m_axis_tuser;   // error

    fixed_window_modexp #(.WIDTH(OPW), .WIN_W(4)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // one expected result word
    typedef struct {
        logic [63:0] word;
        logic [5:0]  index;
        logic        last;
        logic        error;
    } t_result_word;

    // mirror of the operand stores
    logic [OPW-1:0] mod_mirror;
    logic [OPW-1:0] base_mirror;
    logic [OPW-1:0] exp_mirror;

    t_result_word pending_words[$];
    int  mismatch_cnt;
    bit  quiet_sender;    // no gaps on the input side
    bit  quiet_receiver;  // no stalls on the output side
    bit  long_hold_req;   // receiver holds off once when a result shows up

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // generous watchdog, far above the slowest correct run
    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // base^exp mod m by plain square and multiply over wide integers
    function automatic logic [OPW-1:0] mod_power(logic [OPW-1:0] b, logic [OPW-1:0] e,
                                                 logic [OPW-1:0] m);
        logic [2*OPW-1:0] acc;
        logic [2*OPW-1:0] bb;
        logic [2*OPW-1:0] mm;
        mm  = {{OPW{1'b0}}, m};
        acc = 1 % mm;
        bb  = {{OPW{1'b0}}, b} % mm;
        for (int i = OPW - 1; i >= 0; i--) begin
            acc = (acc * acc) % mm;
            if (e[i]) acc = (acc * bb) % mm;
        end
        return acc[OPW-1:0];
    endfunction

    // update the mirror or queue the result words of a start
    task automatic predict_transaction(logic [1:0] mode, logic [5:0] idx, logic [63:0] val);
        logic [OPW-1:0] power;
        t_result_word   rw;
        bit             zero_mod;
        if (mode != fwm_pkg::MODE_START) begin
            if (idx < NWORD) begin
                case (mode)
                    fwm_pkg::MODE_MOD:  mod_mirror[idx*64 +: 64]  = val;
                    fwm_pkg::MODE_BASE: base_mirror[idx*64 +: 64] = val;
                    default:            exp_mirror[idx*64 +: 64]  = val;
                endcase
            end
        end else begin
            zero_mod = (mod_mirror == '0);
            power    = zero_mod ? '0 : mod_power(base_mirror, exp_mirror, mod_mirror);
            for (int k = 0; k < NWORD; k++) begin
                rw.word  = power[k*64 +: 64];
                rw.index = k[5:0];
                rw.last  = (k == NWORD - 1);
                rw.error = zero_mod;
                pending_words.push_back(rw);
            end
        end
    endtask

    // offer one transaction; valid stays high for a back to back follower
    task automatic send_item(logic [1:0] mode, logic [5:0] idx, logic [63:0] val);
        int gap;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, val, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_transaction(mode, idx, val);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_operand(logic [1:0] mode, logic [OPW-1:0] v);
        for (int k = 0; k < NWORD; k++) send_item(mode, k[5:0], v[k*64 +: 64]);
    endtask

    task automatic run_power(logic [OPW-1:0] m, logic [OPW-1:0] b, logic [OPW-1:0] e);
        load_operand(fwm_pkg::MODE_MOD, m);
        load_operand(fwm_pkg::MODE_BASE, b);
        load_operand(fwm_pkg::MODE_EXP, e);
        send_item(fwm_pkg::MODE_START, 6'd0, {$urandom, $urandom});
    endtask

    task automatic wait_drain();
        stop_sending();
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls plus one long counted hold-off on request
    always @(posedge i_clk) begin
        int hold_left;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (long_hold_req && m_axis_tvalid) begin
            long_hold_req = 1'b0;
            hold_left     = 600;
            m_axis_tready <= 1'b0;
        end else if (quiet_receiver) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    // result checker against the oldest expected word
    always @(posedge i_clk) begin
        t_result_word exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result transaction: word %h index %0d",
                             m_axis_tdata[63:0], m_axis_tdata[69:64]);
            end else begin
                exp_w = pending_words.pop_front();
                if (m_axis_tdata[63:0] !== exp_w.word || m_axis_tdata[69:64] !== exp_w.index ||
                    m_axis_tlast !== exp_w.last || m_axis_tuser !== exp_w.error) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"result mismatch: exp word %h idx %0d last %b err %b,",
                                  " got %h %0d %b %b"},
                                 exp_w.word, exp_w.index, exp_w.last, exp_w.error,
                                 m_axis_tdata[63:0], m_axis_tdata[69:64], m_axis_tlast,
                                 m_axis_tuser);
                end
            end
        end
    end

    function automatic logic [OPW-1:0] rand_wide();
        logic [OPW-1:0] v;
        for (int k = 0; k < OPW / 32; k++) v[k*32 +: 32] = $urandom;
        return v;
    endfunction

    // zero modulus straight after reset flags an error with zero words
    task automatic test_zero_modulus();
        load_operand(fwm_pkg::MODE_BASE, rand_wide());
        load_operand(fwm_pkg::MODE_EXP, 256'd5);
        send_item(fwm_pkg::MODE_START, 6'd0, '0);
        wait_drain();
    endtask

    // exponent zero gives one, and modulus one gives zero
    task automatic test_zero_exponent();
        run_power(rand_wide(), rand_wide(), '0);
        run_power(256'd1, 256'd7, '0);
        run_power(256'd1, 256'd7, 256'd3);
        wait_drain();
    endtask

    // base at and above the modulus, all-ones operands, a full width exponent, a zero base
    task automatic test_extremes();
        run_power(256'd97, 256'd97, 256'd13);
        run_power(256'd97, {OPW{1'b1}}, 256'd250);
        run_power({OPW{1'b1}}, {OPW{1'b1}}, 256'hff);
        run_power({OPW{1'b1}} >> 1, rand_wide(), rand_wide());
        run_power(rand_wide(), 256'd0, 256'd9);
        wait_drain();
    endtask

    // loads beyond the operand width are ignored
    task automatic test_ignored_index();
        send_item(fwm_pkg::MODE_MOD, 6'd63, {64{1'b1}});
        send_item(fwm_pkg::MODE_BASE, 6'd4, {64{1'b1}});
        send_item(fwm_pkg::MODE_EXP, 6'd42, 64'h5555_5555_5555_5555);
        send_item(fwm_pkg::MODE_EXP, 6'd21, 64'haaaa_aaaa_aaaa_aaaa);
        run_power(256'd1000003, 256'd2, 256'd20);
        wait_drain();
    endtask

    // receiver holds off long while the sender keeps offering loads
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        quiet_sender  = 1'b1;
        run_power(rand_wide(), rand_wide(), 256'd11);
        run_power(rand_wide(), rand_wide(), 256'd6);
        quiet_sender = 1'b0;
        wait_drain();
    endtask

    task automatic test_random();
        logic [OPW-1:0] m;
        logic [OPW-1:0] e;
        int             r;
        for (int n = 0; n < 13; n++) begin
            quiet_sender   = ($urandom_range(0, 5) == 0);
            quiet_receiver = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 19);
            if (r == 0)      m = '0;
            else if (r < 4)  m = {192'd0, 32'd0, $urandom} >> $urandom_range(0, 31);
            else             m = rand_wide() >> $urandom_range(0, 200);
            e = {224'd0, $urandom} >> $urandom_range(22, 32);
            if ($urandom_range(0, 3) == 0)
                send_item(2'($urandom_range(0, 2)), 6'($urandom_range(4, 63)),
                          {$urandom, $urandom});
            run_power(m, rand_wide(), e);
            if ($urandom_range(0, 3) == 0) wait_drain();
        end
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        wait_drain();
    endtask

    initial begin
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = fwm_pkg::MODE_MOD;
        mod_mirror     = '0;
        base_mirror    = '0;
        exp_mirror     = '0;
        mismatch_cnt   = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        long_hold_req  = 1'b0;
        i_rst_n        = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_modulus();
        test_zero_exponent();
        test_ignored_index();
        test_extremes();
        test_backpressure();
        test_random();

        repeat (200) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
